>>> rtl/core/lni_pkg.sv
// shared types, register defaults and init command table for the lcd nibble interface
package lni_pkg;

   // request kinds carried in the input word's tuser
   typedef enum logic [1:0] {
      REQ_TICK = 2'd0,
      REQ_CMD  = 2'd1,
      REQ_DATA = 2'd2,
      REQ_INIT = 2'd3
   } req_kind_type;

   // configuration register indexes
   typedef enum logic [1:0] {
      CSR_PULSE_TICKS = 2'd0,
      CSR_SHORT_WAIT  = 2'd1,
      CSR_LONG_WAIT   = 2'd2,
      CSR_POWER_UP    = 2'd3
   } csr_index_type;

   localparam logic [7:0]  PULSE_TICKS_RST = 8'd1;
   localparam logic [15:0] SHORT_WAIT_RST  = 16'd40;
   localparam logic [15:0] LONG_WAIT_RST   = 16'd1700;
   localparam logic [15:0] POWER_UP_RST    = 16'd40000;

   localparam int          CSR_DATA_W      = 16;
   localparam logic [3:0]  WAKE_NIBBLE     = 4'h3;
   localparam logic [2:0]  INIT_COUNT      = 3'd5;
   localparam logic [7:0]  LONG_CMD_LIMIT  = 8'd4;

   // timing registers as seen by the sequencer
   typedef struct packed {
      logic [7:0]  pulse_ticks;
      logic [15:0] short_wait_ticks;
      logic [15:0] long_wait_ticks;
      logic [15:0] power_up_ticks;
   } cfg_type;

   // pin levels and status for one result word
   typedef struct packed {
      logic       rejected;
      logic       ready_res;
      logic [3:0] data_nibble;
      logic       enable_pin;
      logic       read_write;
      logic       reg_select;
   } pins_type;

   // init command sequence: function set twice, display on, clear, entry mode
   function automatic logic [7:0] init_byte(input logic [2:0] k);
      logic [7:0] b;
      unique case (k)
         3'd0:    b = 8'h28;
         3'd1:    b = 8'h28;
         3'd2:    b = 8'h0F;
         3'd3:    b = 8'h01;
         3'd4:    b = 8'h06;
         default: b = 8'h06;
      endcase
      return b;
   endfunction

endpackage

>>> rtl/core/lcd_nibble_interface_top.sv
// top level of the 4-bit character lcd interface: csr, sequencer and result register
//
// Usage: every word on the req channel is one microsecond tick of the lcd
// timing. req_tuser carries the kind (tick, command byte, data byte, start
// init) and req_tdata the byte. Each accepted word yields exactly one rsp
// word with the pin levels (RS, RW, E, DB7..DB4) after that tick, a ready
// flag and a rejected flag for requests that arrived while busy.
// The word accepted shows on rsp in the next cycle. Throughput is one word
// per cycle while the rsp side does not stall; the sequencer step is a single
// counter decrement or phase change between the state registers and the
// result register.
// The csr port sets pulse, short wait, long wait and power-up lengths in
// ticks; write it only while no words are in flight.
// Reset (synchronous) returns the sequencer to idle with RS and data low and
// loads the default timing. When the rsp side stalls, the held result stays
// and req_tready falls; no tick advances until the result is taken.
module lcd_nibble_interface_top #(
   parameter int WAIT_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,  // [7:0] byte_value
   input  logic [1:0]                      req_tuser,  // [1:0] req_type
   // result channel
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [0] reg_select, [1] read_write, [2] enable_pin, [6:3] data_nibble,
   // [7] ready_res, [8] rejected, [15:9] zero
   output logic [15:0]                     rsp_tdata,
   // configuration
   input  logic                            csr_we,
   input  logic [1:0]                      csr_index,
   input  logic [lni_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import lni_pkg::*;

   cfg_type    cfg;
   pins_type   pins;
   logic       step_en;
   logic       rsp_valid_ff;
   pins_type   rsp_pins_ff;

   lni_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // accept while the result register is empty or being drained
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign step_en    = req_tvalid && req_tready;

   lni_seq #(
      .WAIT_BITS (WAIT_BITS)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .step_en    (step_en),
      .req_type   (req_tuser),
      .byte_value (req_tdata),
      .cfg        (cfg),
      .pins       (pins)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step_en) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         rsp_pins_ff <= pins;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_pins_ff};

endmodule

>>> rtl/core/lni_csr.sv
// timing configuration registers of the lcd nibble interface
module lni_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [1:0]                          csr_index,
   input  logic [lni_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output lni_pkg::cfg_type                    cfg
);
   import lni_pkg::*;

   cfg_type cfg_ff;

   // register writes, one index per write
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pulse_ticks      <= PULSE_TICKS_RST;
         cfg_ff.short_wait_ticks <= SHORT_WAIT_RST;
         cfg_ff.long_wait_ticks  <= LONG_WAIT_RST;
         cfg_ff.power_up_ticks   <= POWER_UP_RST;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_PULSE_TICKS: cfg_ff.pulse_ticks      <= csr_wdata[7:0];
            CSR_SHORT_WAIT:  cfg_ff.short_wait_ticks <= csr_wdata[15:0];
            CSR_LONG_WAIT:   cfg_ff.long_wait_ticks  <= csr_wdata[15:0];
            CSR_POWER_UP:    cfg_ff.power_up_ticks   <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> rtl/core/lni_seq.sv
// nibble sequencer: phase, wait counter, held byte and init step, one step per word
module lni_seq #(
   parameter int WAIT_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              step_en,
   input  logic [1:0]        req_type,
   input  logic [7:0]        byte_value,
   input  lni_pkg::cfg_type  cfg,
   output lni_pkg::pins_type pins
);
   import lni_pkg::*;

   typedef enum logic [2:0] {
      PH_IDLE      = 3'd0,
      PH_POWER     = 3'd1,
      PH_WAKE_E    = 3'd2,
      PH_WAKE_WAIT = 3'd3,
      PH_HI_E      = 3'd4,
      PH_HI_GAP    = 3'd5,
      PH_LO_E      = 3'd6,
      PH_SETTLE    = 3'd7
   } phase_type;

   localparam logic [31:0] WAIT_CAP = 32'((64'd1 << WAIT_BITS) - 64'd1);
   localparam logic [WAIT_BITS-1:0] WAIT_ONE = {{(WAIT_BITS-1){1'b0}}, 1'b1};

   phase_type            phase_ff, phase_in;
   logic [WAIT_BITS-1:0] wait_count_ff, wait_count_in;
   logic [7:0]           held_byte_ff, held_byte_in;
   logic                 held_select_ff, held_select_in;
   logic [2:0]           init_step_ff, init_step_in;
   logic                 rejected;
   logic                 long_settle;

   // phase length in ticks to counter load: zero acts as one, saturate to counter
   function automatic logic [WAIT_BITS-1:0] to_wait(input logic [15:0] ticks);
      logic [15:0] d;
      logic [31:0] wide;
      d    = (ticks == 16'd0) ? 16'd0 : ticks - 16'd1;
      wide = {16'd0, d};
      if (wide > WAIT_CAP) begin
         wide = WAIT_CAP;
      end
      return wide[WAIT_BITS-1:0];
   endfunction

   assign long_settle = !held_select_ff && (held_byte_ff < LONG_CMD_LIMIT);

   // next state for one tick
   always_comb begin
      phase_in       = phase_ff;
      wait_count_in  = wait_count_ff;
      held_byte_in   = held_byte_ff;
      held_select_in = held_select_ff;
      init_step_in   = init_step_ff;
      rejected       = 1'b0;
      if (phase_ff == PH_IDLE) begin
         unique case (req_kind_type'(req_type))
            REQ_CMD, REQ_DATA: begin
               init_step_in   = 3'd0;
               held_byte_in   = byte_value;
               held_select_in = (req_kind_type'(req_type) == REQ_DATA);
               phase_in       = PH_HI_E;
               wait_count_in  = to_wait({8'd0, cfg.pulse_ticks});
            end
            REQ_INIT: begin
               init_step_in  = 3'd0;
               phase_in      = PH_POWER;
               wait_count_in = to_wait(cfg.power_up_ticks);
            end
            default: ;
         endcase
      end else begin
         rejected = (req_kind_type'(req_type) != REQ_TICK);
         if (wait_count_ff != '0) begin
            wait_count_in = wait_count_ff - WAIT_ONE;
         end else begin
            unique case (phase_ff)
               PH_POWER: begin
                  phase_in      = PH_WAKE_E;
                  wait_count_in = to_wait({8'd0, cfg.pulse_ticks});
               end
               PH_WAKE_E: begin
                  phase_in      = PH_WAKE_WAIT;
                  wait_count_in = to_wait(cfg.short_wait_ticks);
               end
               PH_WAKE_WAIT: begin
                  init_step_in   = 3'd1;
                  held_byte_in   = init_byte(3'd0);
                  held_select_in = 1'b0;
                  phase_in       = PH_HI_E;
                  wait_count_in  = to_wait({8'd0, cfg.pulse_ticks});
               end
               PH_HI_E: begin
                  phase_in      = PH_HI_GAP;
                  wait_count_in = to_wait({8'd0, cfg.pulse_ticks});
               end
               PH_HI_GAP: begin
                  phase_in      = PH_LO_E;
                  wait_count_in = to_wait({8'd0, cfg.pulse_ticks});
               end
               PH_LO_E: begin
                  phase_in      = PH_SETTLE;
                  wait_count_in = long_settle ? to_wait(cfg.long_wait_ticks)
                                              : to_wait(cfg.short_wait_ticks);
               end
               PH_SETTLE: begin
                  if (init_step_ff != 3'd0 && init_step_ff < INIT_COUNT) begin
                     init_step_in   = init_step_ff + 3'd1;
                     held_byte_in   = init_byte(init_step_ff);
                     held_select_in = 1'b0;
                     phase_in       = PH_HI_E;
                     wait_count_in  = to_wait({8'd0, cfg.pulse_ticks});
                  end else begin
                     init_step_in  = 3'd0;
                     phase_in      = PH_IDLE;
                     wait_count_in = '0;
                  end
               end
               default: begin
                  phase_in      = PH_IDLE;
                  wait_count_in = '0;
               end
            endcase
         end
      end
   end

   // pin levels after this tick
   always_comb begin
      pins             = '0;
      pins.read_write  = 1'b0;
      pins.rejected    = rejected;
      pins.ready_res   = (phase_in == PH_IDLE);
      unique case (phase_in)
         PH_POWER: begin
            pins.reg_select  = 1'b0;
            pins.data_nibble = 4'h0;
         end
         PH_WAKE_E: begin
            pins.reg_select  = 1'b0;
            pins.data_nibble = WAKE_NIBBLE;
            pins.enable_pin  = 1'b1;
         end
         PH_WAKE_WAIT: begin
            pins.reg_select  = 1'b0;
            pins.data_nibble = WAKE_NIBBLE;
         end
         PH_HI_E: begin
            pins.reg_select  = held_select_in;
            pins.data_nibble = held_byte_in[7:4];
            pins.enable_pin  = 1'b1;
         end
         PH_HI_GAP: begin
            pins.reg_select  = held_select_in;
            pins.data_nibble = held_byte_in[7:4];
         end
         PH_LO_E: begin
            pins.reg_select  = held_select_in;
            pins.data_nibble = held_byte_in[3:0];
            pins.enable_pin  = 1'b1;
         end
         default: begin
            pins.reg_select  = held_select_in;
            pins.data_nibble = held_byte_in[3:0];
         end
      endcase
   end

   // sequencer state, advanced once per accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         wait_count_ff  <= '0;
         held_byte_ff   <= 8'd0;
         held_select_ff <= 1'b0;
         init_step_ff   <= 3'd0;
      end else if (step_en) begin
         phase_ff       <= phase_in;
         wait_count_ff  <= wait_count_in;
         held_byte_ff   <= held_byte_in;
         held_select_ff <= held_select_in;
         init_step_ff   <= init_step_in;
      end
   end

   // an init sequence in progress never sits in idle
   a_init_busy: assert property (@(posedge clock) disable iff (reset)
      init_step_ff != 3'd0 |-> phase_ff != PH_IDLE)
      else $error("init step set while idle");

   // a byte request taken while idle starts the high nibble strobe
   a_byte_start: assert property (@(posedge clock) disable iff (reset)
      step_en && phase_ff == PH_IDLE &&
      (req_type == REQ_CMD || req_type == REQ_DATA) |=> phase_ff == PH_HI_E)
      else $error("byte request did not start high nibble");

   // idle never drops a request
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_IDLE |-> !pins.rejected)
      else $error("request rejected while idle");

   // the strobe is only high while the sequencer is busy
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      pins.enable_pin |-> !pins.ready_res)
      else $error("enable high while ready");

endmodule
